FILE: rtl/oaid_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package oaid_pkg;

	typedef enum logic [2:0] {
		FN_APPEND  = 3'd0,
		FN_SORTED  = 3'd1,
		FN_INS_POS = 3'd2,
		FN_DELETE  = 3'd3,
		FN_READ    = 3'd4,
		FN_CLEAR   = 3'd5
	} func_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_NOT_FOUND = 2'd2,
		STAT_BAD_POS   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS,
		S_PUT,
		S_DEL,
		S_RD,
		S_DONE
	} state_t;

	localparam int unsigned DataW  = 32;
	localparam int unsigned PosW   = 7;
	localparam int unsigned CountW = 7;

endpackage
`default_nettype wire

FILE: rtl/oaid_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module oaid_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

FILE: rtl/oaid_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module oaid_ctrl
	import oaid_pkg::*;
#(
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int unsigned UW = $clog2(DEPTH + 1)
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [2:0]               func,
	input  wire logic signed [DataW-1:0]  value,
	input  wire logic [PosW-1:0]          position,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic [1:0]                    status,
	output logic [CountW-1:0]             count,
	output logic signed [DataW-1:0]       read_value,
	output logic                          ram_we,
	output logic [AW-1:0]                 ram_waddr,
	output logic [DataW-1:0]              ram_wdata,
	output logic [AW-1:0]                 ram_raddr,
	input  wire logic signed [DataW-1:0]  ram_rdata
);

	localparam int unsigned CW = ((UW > PosW) ? UW : PosW) + 1;

	state_t state_q, state_d;
	logic [UW-1:0] used_q, used_d;
	logic [UW-1:0] k_q, k_d;
	logic [UW-1:0] idx_q, idx_d;
	logic found_q, found_d;
	logic sort_q, sort_d;
	logic out_valid_q, out_valid_d;
	logic signed [DataW-1:0] val_q, val_d;
	logic signed [DataW-1:0] rd_q, rd_d;
	status_t stat_q, stat_d;
	status_t ostat_q, ostat_d;
	logic [CountW-1:0] count_q, count_d;
	logic signed [DataW-1:0] orv_q, orv_d;

	logic [CW-1:0] posx, usedx, pm1;
	logic [UW-1:0] um1, up1, km1, km2, kp1;
	logic full, hit;

	assign posx  = CW'(position);
	assign usedx = CW'(used_q);
	assign pm1   = posx - 1'b1;
	assign um1   = used_q - 1'b1;
	assign up1   = used_q + 1'b1;
	assign km1   = k_q - 1'b1;
	assign km2   = k_q - 2'd2;
	assign kp1   = k_q + 1'b1;
	assign full  = (used_q == UW'(DEPTH));
	assign hit   = (ram_rdata == val_q);

	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = out_valid_q;
	assign status     = ostat_q;
	assign count      = count_q;
	assign read_value = orv_q;

	always_comb begin
		state_d     = state_q;
		used_d      = used_q;
		k_d         = k_q;
		idx_d       = idx_q;
		found_d     = found_q;
		sort_d      = sort_q;
		val_d       = val_q;
		rd_d        = rd_q;
		stat_d      = stat_q;
		ostat_d     = ostat_q;
		count_d     = count_q;
		orv_d       = orv_q;
		out_valid_d = out_valid_q && !out_ready;
		ram_we      = 1'b0;
		ram_waddr   = k_q[AW-1:0];
		ram_wdata   = ram_rdata;
		ram_raddr   = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					val_d  = value;
					rd_d   = '0;
					stat_d = STAT_OK;
					state_d = S_DONE;
					case (func_t'(func))
						FN_APPEND: begin
							if (full) begin
								stat_d = STAT_FULL;
							end else begin
								ram_we    = 1'b1;
								ram_waddr = used_q[AW-1:0];
								ram_wdata = value;
								used_d    = up1;
							end
						end
						FN_SORTED: begin
							if (full) begin
								stat_d = STAT_FULL;
							end else if (used_q == '0) begin
								ram_we    = 1'b1;
								ram_waddr = '0;
								ram_wdata = value;
								used_d    = up1;
							end else begin
								k_d       = used_q;
								idx_d     = '0;
								sort_d    = 1'b1;
								ram_raddr = um1[AW-1:0];
								state_d   = S_INS;
							end
						end
						FN_INS_POS: begin
							if (full) begin
								stat_d = STAT_FULL;
							end else if (posx == '0 || posx > usedx + 1'b1) begin
								stat_d = STAT_BAD_POS;
							end else if (posx == usedx + 1'b1) begin
								ram_we    = 1'b1;
								ram_waddr = used_q[AW-1:0];
								ram_wdata = value;
								used_d    = up1;
							end else begin
								k_d       = used_q;
								idx_d     = UW'(pm1);
								sort_d    = 1'b0;
								ram_raddr = um1[AW-1:0];
								state_d   = S_INS;
							end
						end
						FN_DELETE: begin
							stat_d = STAT_NOT_FOUND;
							if (used_q != '0) begin
								k_d       = '0;
								found_d   = 1'b0;
								ram_raddr = '0;
								state_d   = S_DEL;
							end
						end
						FN_READ: begin
							if (posx == '0 || posx > usedx) begin
								stat_d = STAT_BAD_POS;
							end else begin
								ram_raddr = pm1[AW-1:0];
								state_d   = S_RD;
							end
						end
						FN_CLEAR: begin
							used_d = '0;
						end
						default: begin
						end
					endcase
				end
			end
			S_INS: begin
				ram_we    = 1'b1;
				ram_waddr = k_q[AW-1:0];
				if (!sort_q || ram_rdata >= val_q) begin
					ram_wdata = ram_rdata;
					k_d       = km1;
					if (km1 > idx_q) begin
						ram_raddr = km2[AW-1:0];
					end else begin
						state_d = S_PUT;
					end
				end else begin
					ram_wdata = val_q;
					used_d    = up1;
					state_d   = S_DONE;
				end
			end
			S_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = k_q[AW-1:0];
				ram_wdata = val_q;
				used_d    = up1;
				state_d   = S_DONE;
			end
			S_DEL: begin
				// after the match, each beat read moves down one slot
				if (found_q) begin
					ram_we    = 1'b1;
					ram_waddr = km1[AW-1:0];
					ram_wdata = ram_rdata;
				end else if (hit) begin
					found_d = 1'b1;
				end
				if (kp1 < used_q) begin
					k_d       = kp1;
					ram_raddr = kp1[AW-1:0];
				end else begin
					if (found_q || hit) begin
						used_d = um1;
						stat_d = STAT_OK;
					end
					state_d = S_DONE;
				end
			end
			S_RD: begin
				rd_d    = ram_rdata;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_valid_d = 1'b1;
					ostat_d     = stat_q;
					count_d     = CountW'(used_q);
					orv_d       = rd_q;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			used_q      <= used_d;
			found_q     <= found_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		k_q     <= k_d;
		idx_q   <= idx_d;
		sort_q  <= sort_d;
		val_q   <= val_d;
		rd_q    <= rd_d;
		stat_q  <= stat_d;
		ostat_q <= ostat_d;
		count_q <= count_d;
		orv_q   <= orv_d;
	end

endmodule
`default_nettype wire

FILE: rtl/ordered_array_insert_delete_top.sv
// Append, clear, bad or full ops go straight to the result state; read adds a RAM read state.
// Insert walks the single RAM port pair down from the top, one entry a cycle.
// Delete scans upward from entry 0 and shifts later entries down one slot.
// One item in flight at a time; result register lets the next beat start.
// Reset clears the count and handshake state; array contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module ordered_array_insert_delete_top
	import oaid_pkg::*;
#(
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [2:0]              func,
	input  wire logic signed [DataW-1:0] value,
	input  wire logic [PosW-1:0]         position,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic [1:0]                   status,
	output logic [CountW-1:0]            count,
	output logic signed [DataW-1:0]      read_value
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [DataW-1:0]  ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [DataW-1:0]  ram_rdata;

	oaid_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.value      (value),
		.position   (position),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.count      (count),
		.read_value (read_value),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata)
	);

	oaid_ram #(
		.WIDTH(DataW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule
`default_nettype wire
